// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the range offset encoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error(msg);

`endif

// File: rtl/brto_pkg.sv
// ---------------------------------------------------------------------------
// Range offset encoder package
// Port widths, codes and shared types of the bitmap to range offset encoder.
// ---------------------------------------------------------------------------
package brto_pkg;

  // Fixed widths of the payload ports.
  localparam int unsigned POS_PORT_BITS  = 32;
  localparam int unsigned WORD_PORT_BITS = 64;
  localparam int unsigned OFFSET_BITS    = 32;

  // Each lane scans one byte of the bitmap word.
  localparam int unsigned LANE_BITS     = 8;
  localparam int unsigned LANE_IDX_BITS = 3;

  // Input command codes.
  typedef enum logic {
    CMD_WORD   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  // Meaning of an emitted offset.
  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_GAP    = 2'd1,
    KIND_LENGTH = 2'd2
  } kind_e;

  // What one lane found in its byte.
  typedef struct packed {
    logic                     hit;
    logic [LANE_IDX_BITS-1:0] idx;
  } lane_hit_t;

  // Control flags that travel with one run.
  typedef struct packed {
    logic finish;
    logic last;
  } run_ctl_t;

endpackage

// File: rtl/bitmap_to_range_offsets.sv
// ---------------------------------------------------------------------------
// Bitmap to range offsets encoder
// Turns a stream of bitmap words into run-length range offsets.
// ---------------------------------------------------------------------------
// Usage: the input channel takes one transaction per item, either a bitmap
// word with the position of its bit 0 (cmd 0) or a finish command (cmd 1).
// The output channel carries one offset per transaction: absolute first start,
// gap from the previous range end, or range length minus one; last_of_item
// marks the final offset an item causes. Items that cause no offset produce
// no output transaction.
// Path: the offsets of a word pass through the capture, run and output registers.
// Throughput: a capture register, a run register and the output register
// form a three-stage pipeline. The lane finder extracts one run per cycle
// while the run register has room, so a word with several runs stays in the
// capture register until its last run is taken; each run that opens a new
// range needs two output transactions (length, then gap), which sets the rate of dense words.
// Reset: all stages empty, no range open, positions cleared.
// Stall: when the receiver holds ready low the output register keeps its
// offset; the run and capture registers fill and then input ready drops.
// ---------------------------------------------------------------------------
module bitmap_to_range_offsets #(
  parameter int unsigned WORD_BITS     = 64,
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                cmd_i,
  input  logic [brto_pkg::POS_PORT_BITS-1:0]  word_position_i,
  input  logic [brto_pkg::WORD_PORT_BITS-1:0] bit_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [brto_pkg::OFFSET_BITS-1:0]    offset_value_o,
  output logic [1:0]                          offset_kind_o,
  output logic                                last_of_item_o
);
  import brto_pkg::*;

  localparam int unsigned IdxBits = $clog2(WORD_BITS);

  logic                     in_accept;
  logic [WORD_BITS-1:0]     word;
  logic [WORD_BITS-1:0]     start_in;
  logic [WORD_BITS-1:0]     end_in;

  logic                     cap_valid_q, cap_valid_d;
  logic                     cap_finish_q;
  logic [POSITION_BITS-1:0] cap_base_q;
  logic [WORD_BITS-1:0]     cap_start_q;
  logic [WORD_BITS-1:0]     cap_end_q;
  logic                     cap_done;

  logic                     start_found, end_found;
  logic [IdxBits-1:0]       start_idx, end_idx;
  logic [WORD_BITS-1:0]     start_onehot, end_onehot;
  logic [WORD_BITS-1:0]     start_rest, end_rest;

  logic                     run_valid_q, run_valid_d;
  run_ctl_t                 run_ctl_q;
  logic [POSITION_BITS-1:0] run_first_pos_q;
  logic [POSITION_BITS-1:0] run_end_pos_q;
  logic                     run_ready;
  logic                     run_load;
  logic                     run_take;

  // Run boundaries of the incoming word: a start is a set bit whose lower
  // neighbour is clear, an end is a set bit whose upper neighbour is clear.
  assign word      = bit_word_i[WORD_BITS-1:0];
  assign start_in  = word & ~(word << 1);
  assign end_in    = word & ~(word >> 1);
  assign in_accept = in_valid_i && in_ready_o;

  // Lane finders for the next run start and its end.
  brto_finder #(
    .WORD_BITS (WORD_BITS),
    .IDX_BITS  (IdxBits)
  ) u_find_start (
    .mask_i   (cap_start_q),
    .found_o  (start_found),
    .idx_o    (start_idx),
    .onehot_o (start_onehot)
  );

  brto_finder #(
    .WORD_BITS (WORD_BITS),
    .IDX_BITS  (IdxBits)
  ) u_find_end (
    .mask_i   (cap_end_q),
    .found_o  (end_found),
    .idx_o    (end_idx),
    .onehot_o (end_onehot)
  );

  assign start_rest = cap_start_q & ~start_onehot;
  assign end_rest   = cap_end_q & ~end_onehot;
  assign run_ready  = !run_valid_q || run_take;

  // Capture stage sequencing: one run leaves per cycle while there is room.
  always_comb begin
    run_load = 1'b0;
    cap_done = 1'b0;
    if (cap_valid_q) begin
      if (cap_finish_q) begin
        run_load = run_ready;
        cap_done = run_ready;
      end else if (!(start_found && end_found)) begin
        cap_done = 1'b1;
      end else begin
        run_load = run_ready;
        cap_done = run_ready && (start_rest == '0);
      end
    end
  end

  assign in_ready_o  = !cap_valid_q || cap_done;
  assign cap_valid_d = in_accept || (cap_valid_q && !cap_done);
  assign run_valid_d = run_load || (run_valid_q && !run_take);

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
      run_valid_q <= 1'b0;
    end else begin
      cap_valid_q <= cap_valid_d;
      run_valid_q <= run_valid_d;
    end
  end

  // Capture payload: load on a transaction, shrink as runs are taken.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cap_finish_q <= (cmd_i == CMD_FINISH);
      cap_base_q   <= POSITION_BITS'(word_position_i);
      cap_start_q  <= start_in;
      cap_end_q    <= end_in;
    end else if (run_load) begin
      cap_start_q <= start_rest;
      cap_end_q   <= end_rest;
    end
  end

  // Run payload: absolute first and last position of the run.
  always_ff @(posedge clk_i) begin
    if (run_load) begin
      run_ctl_q.finish <= cap_finish_q;
      run_ctl_q.last   <= cap_finish_q || (start_rest == '0);
      run_first_pos_q  <= cap_base_q + POSITION_BITS'(start_idx);
      run_end_pos_q    <= cap_base_q + POSITION_BITS'(end_idx);
    end
  end

  brto_emit #(
    .POSITION_BITS (POSITION_BITS)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .run_valid_i     (run_valid_q),
    .run_ctl_i       (run_ctl_q),
    .run_first_pos_i (run_first_pos_q),
    .run_end_pos_i   (run_end_pos_q),
    .run_take_o      (run_take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .offset_value_o  (offset_value_o),
    .offset_kind_o   (offset_kind_o),
    .last_of_item_o  (last_of_item_o)
  );

endmodule

// File: rtl/brto_lane.sv
// ---------------------------------------------------------------------------
// Lane scanner
// Finds the lowest set bit within one byte-wide lane of a mask.
// ---------------------------------------------------------------------------
module brto_lane (
  input  logic [brto_pkg::LANE_BITS-1:0] bits_i,
  output brto_pkg::lane_hit_t            hit_o
);
  import brto_pkg::*;

  // Priority encode toward the lowest bit.
  always_comb begin
    hit_o.hit = |bits_i;
    hit_o.idx = '0;
    for (int i = LANE_BITS - 1; i >= 0; i--) begin
      if (bits_i[i]) begin
        hit_o.idx = LANE_IDX_BITS'(i);
      end
    end
  end

endmodule

// File: rtl/brto_finder.sv
// ---------------------------------------------------------------------------
// Lowest bit finder
// Splits a mask into lanes, scans them side by side and merges the results
// into the index and one-hot mask of the lowest set bit.
// ---------------------------------------------------------------------------
module brto_finder #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned IDX_BITS  = 6
) (
  input  logic [WORD_BITS-1:0] mask_i,
  output logic                 found_o,
  output logic [IDX_BITS-1:0]  idx_o,
  output logic [WORD_BITS-1:0] onehot_o
);
  import brto_pkg::*;

  localparam int unsigned NumLanes = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
  localparam int unsigned PadBits  = NumLanes * LANE_BITS;

  logic [PadBits-1:0]        mask_pad;
  lane_hit_t [NumLanes-1:0]  hits;

  assign mask_pad = PadBits'(mask_i);

  // One scanner per lane.
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    brto_lane u_lane (
      .bits_i (mask_pad[l*LANE_BITS +: LANE_BITS]),
      .hit_o  (hits[l])
    );
  end

  // Merge: the lowest lane with a hit wins.
  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int l = NumLanes - 1; l >= 0; l--) begin
      if (hits[l].hit) begin
        found_o = 1'b1;
        idx_o   = IDX_BITS'(l * LANE_BITS) | IDX_BITS'(hits[l].idx);
      end
    end
  end

  // Decode the winner so the caller can clear it.
  assign onehot_o = found_o ? (WORD_BITS'(1) << idx_o) : '0;

endmodule

// File: rtl/brto_emit.sv
// ---------------------------------------------------------------------------
// Offset emitter
// Holds the encoder state, turns each run into its offsets and drives the
// output register, one offset per transaction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brto_emit #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               run_valid_i,
  input  brto_pkg::run_ctl_t                 run_ctl_i,
  input  logic [POSITION_BITS-1:0]           run_first_pos_i,
  input  logic [POSITION_BITS-1:0]           run_end_pos_i,
  output logic                               run_take_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [brto_pkg::OFFSET_BITS-1:0]   offset_value_o,
  output logic [1:0]                         offset_kind_o,
  output logic                               last_of_item_o
);
  import brto_pkg::*;

  logic                     out_valid_q, out_valid_d;
  logic [OFFSET_BITS-1:0]   out_value_q, out_value_d;
  kind_e                    out_kind_q, out_kind_d;
  logic                     out_last_q, out_last_d;
  logic                     pend_valid_q, pend_valid_d;
  logic [OFFSET_BITS-1:0]   pend_value_q, pend_value_d;
  logic                     pend_last_q, pend_last_d;
  logic [POSITION_BITS-1:0] prev_q, prev_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic                     seen_q, seen_d;
  logic                     out_free;
  logic [POSITION_BITS-1:0] len_m1;
  logic [POSITION_BITS-1:0] gap;

  assign out_free = !out_valid_q || out_ready_i;
  assign len_m1   = prev_q - start_q;
  assign gap      = run_first_pos_i - prev_q;

  // Offset generation: a pending gap goes out before the next run is taken.
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_kind_d   = out_kind_q;
    out_last_d   = out_last_q;
    pend_valid_d = pend_valid_q;
    pend_value_d = pend_value_q;
    pend_last_d  = pend_last_q;
    prev_d       = prev_q;
    start_d      = start_q;
    seen_d       = seen_q;
    run_take_o   = 1'b0;
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_value_d  = pend_value_q;
        out_kind_d   = KIND_GAP;
        out_last_d   = pend_last_q;
        pend_valid_d = 1'b0;
      end else if (run_valid_i) begin
        run_take_o = 1'b1;
        if (run_ctl_i.finish) begin
          // Flush the open range and return to the reset state.
          if (seen_q) begin
            out_valid_d = 1'b1;
            out_value_d = OFFSET_BITS'(len_m1);
            out_kind_d  = KIND_LENGTH;
            out_last_d  = 1'b1;
          end
          prev_d  = '0;
          start_d = '0;
          seen_d  = 1'b0;
        end else begin
          if (!seen_q) begin
            // Very first range: absolute start.
            out_valid_d = 1'b1;
            out_value_d = OFFSET_BITS'(run_first_pos_i);
            out_kind_d  = KIND_FIRST;
            out_last_d  = run_ctl_i.last;
            start_d     = run_first_pos_i;
            seen_d      = 1'b1;
          end else if (run_first_pos_i != prev_q + POSITION_BITS'(1)) begin
            // New range: close the old one, then send the gap.
            out_valid_d  = 1'b1;
            out_value_d  = OFFSET_BITS'(len_m1);
            out_kind_d   = KIND_LENGTH;
            out_last_d   = 1'b0;
            pend_valid_d = 1'b1;
            pend_value_d = OFFSET_BITS'(gap);
            pend_last_d  = run_ctl_i.last;
            start_d      = run_first_pos_i;
          end
          prev_d = run_end_pos_i;
        end
      end
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
      prev_q       <= '0;
      start_q      <= '0;
      seen_q       <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
      prev_q       <= prev_d;
      start_q      <= start_d;
      seen_q       <= seen_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_kind_q   <= out_kind_d;
    out_last_q   <= out_last_d;
    pend_value_q <= pend_value_d;
    pend_last_q  <= pend_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign offset_value_o = out_value_q;
  assign offset_kind_o  = out_kind_q;
  assign last_of_item_o = out_last_q;

  // A pending gap only exists once a range is open.
  `ASSERT_PROP(a_pend_needs_seen, clk_i, rst_ni, pend_valid_q |-> seen_q, "gap pending with no range open")
  // A pending gap sits behind a non-final length offset.
  `ASSERT_PROP(a_pend_behind_length, clk_i, rst_ni, pend_valid_q |-> (out_valid_q && out_kind_q == KIND_LENGTH && !out_last_q), "pending gap not behind a length")
  // An absolute start on the output implies an open range.
  `ASSERT_NEVER(a_first_without_seen, clk_i, rst_ni, out_valid_q && out_kind_q == KIND_FIRST && !seen_q, "first start shown with no range open")
  // Finish leaves the encoder in its reset state.
  `ASSERT_PROP(a_finish_clears, clk_i, rst_ni, (run_take_o && run_ctl_i.finish) |=> (!seen_q && !pend_valid_q), "finish did not clear the state")

endmodule
